### rtl/cbm_pkg.sv
// ---------------------------------------------------------------------------
// cbm_pkg
// Shared widths, register indexes, reset values and the configuration struct
// of the cluster size bin mapper.
// ---------------------------------------------------------------------------
package cbm_pkg;

	localparam int SIZE_BITS       = 16;
	localparam int RATIO_FRAC_BITS = 8;
	localparam int RATIO_BITS      = 16;
	localparam int WID_BITS        = SIZE_BITS + 1;           // running bin width
	localparam int COMP_BITS       = SIZE_BITS + 1;           // component indexes
	localparam int PROD_BITS       = WID_BITS + RATIO_BITS;   // shared multiplier out
	localparam int VAR_BITS        = 2 * SIZE_BITS;
	localparam int CFG_IDX_BITS    = 3;

	// width saturates here: any bin this wide runs past the largest size
	localparam logic [WID_BITS-1:0] WIDTH_CAP = WID_BITS'(1) << SIZE_BITS;
	localparam logic [PROD_BITS:0] RATIO_ROUND =
		(PROD_BITS + 1)'((1 << RATIO_FRAC_BITS) - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SIZE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPL_REQ   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GROUP_EN   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_GEOM_MODE  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_BIN  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_GROW_RATIO = 3'd5;

	localparam logic [SIZE_BITS-1:0]  RST_MAX_SIZE   = SIZE_BITS'(256);
	localparam logic [SIZE_BITS-1:0]  RST_EXPL_REQ   = SIZE_BITS'(1);
	localparam logic [SIZE_BITS-1:0]  RST_FIRST_BIN  = SIZE_BITS'(1);
	localparam logic [RATIO_BITS-1:0] RST_GROW_RATIO = RATIO_BITS'(512);

	typedef struct packed {
		logic [SIZE_BITS-1:0]  max_size;
		logic [SIZE_BITS-1:0]  expl_req;
		logic                  grouping_enable;
		logic                  geometric_mode;
		logic [SIZE_BITS-1:0]  first_bin_width;
		logic [RATIO_BITS-1:0] growth_ratio;
	} cfg_t;

endpackage

### rtl/cbm_mul.sv
// ---------------------------------------------------------------------------
// cbm_mul
// Shared multiplier with registered product: bin width times growth ratio
// during the walk, span times span for the variance at the end.
// ---------------------------------------------------------------------------
module cbm_mul import cbm_pkg::*; (
	input  logic                  clk,
	input  logic [WID_BITS-1:0]   a,
	input  logic [RATIO_BITS-1:0] b,
	output logic [PROD_BITS-1:0]  p
);

	logic [PROD_BITS-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_BITS'(a) * PROD_BITS'(b);
	end

	assign p = p_q;

endmodule

### rtl/cbm_cfg_regs.sv
// ---------------------------------------------------------------------------
// cbm_cfg_regs
// Configuration register file, written through the valid/ready port.
// ---------------------------------------------------------------------------
module cbm_cfg_regs import cbm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SIZE_BITS-1:0]    cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_size        <= RST_MAX_SIZE;
			cfg_q.expl_req        <= RST_EXPL_REQ;
			cfg_q.grouping_enable <= 1'b0;
			cfg_q.geometric_mode  <= 1'b0;
			cfg_q.first_bin_width <= RST_FIRST_BIN;
			cfg_q.growth_ratio    <= RST_GROW_RATIO;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_SIZE:   cfg_q.max_size        <= cfg_data;
				REG_EXPL_REQ:   cfg_q.expl_req        <= cfg_data;
				REG_GROUP_EN:   cfg_q.grouping_enable <= cfg_data[0];
				REG_GEOM_MODE:  cfg_q.geometric_mode  <= cfg_data[0];
				REG_FIRST_BIN:  cfg_q.first_bin_width <= cfg_data;
				REG_GROW_RATIO: cfg_q.growth_ratio    <= RATIO_BITS'(cfg_data);
				default: ;  // unmapped index, transfer dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/cbm_walker.sv
// ---------------------------------------------------------------------------
// cbm_walker
// Sequencer that classifies a query, walks the bins one at a time with the
// shared adder/compare and multiplier, and builds the result.
// ---------------------------------------------------------------------------
module cbm_walker import cbm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   start,
	output logic                   busy,
	input  logic [SIZE_BITS-1:0]   size_query,
	output logic                   done,
	output logic                   in_range,
	output logic                   is_explicit,
	output logic [COMP_BITS-1:0]   component_index,
	output logic [COMP_BITS-1:0]   second_component,
	output logic signed [COMP_BITS-1:0] group_number,
	output logic [SIZE_BITS-1:0]   bin_first,
	output logic [SIZE_BITS-1:0]   bin_last,
	output logic [SIZE_BITS-1:0]   bin_span,
	output logic [COMP_BITS-1:0]   mean_doubled,
	output logic [VAR_BITS-1:0]    variance_times_twelve
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_GROW  = 3'd3;
	localparam logic [2:0] ST_SQR   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]           state_q;
	logic [SIZE_BITS-1:0] n_q, e_q, start_q, end_q, span_q, g_q;
	logic [WID_BITS-1:0]  w_q;
	logic                 done_q;

	logic                 in_range_q, is_explicit_q;
	logic [COMP_BITS-1:0] comp_q, second_q, group_q, mean_q;
	logic [SIZE_BITS-1:0] first_q, last_q, span_out_q;
	logic [VAR_BITS-1:0]  var_q;

	// shared multiplier
	logic [WID_BITS-1:0]   mul_a;
	logic [RATIO_BITS-1:0] mul_b;
	logic [PROD_BITS-1:0]  prod;

	cbm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_comb begin
		if (state_q == ST_SQR) begin
			mul_a = WID_BITS'(span_q);
			mul_b = RATIO_BITS'(span_q);
		end else begin
			mul_a = w_q;
			mul_b = cfg.growth_ratio;
		end
	end

	// explicit limit
	logic [SIZE_BITS-1:0] e_clamp, e_calc;
	always_comb begin
		e_clamp = (cfg.expl_req < cfg.max_size) ? cfg.expl_req : cfg.max_size;
		if (!cfg.grouping_enable)
			e_calc = cfg.max_size;
		else if (e_clamp == '0)
			e_calc = SIZE_BITS'(1);
		else
			e_calc = e_clamp;
	end

	logic out_of_range, expl_hit;
	assign out_of_range = (n_q == '0) || (n_q > cfg.max_size);
	assign expl_hit     = (n_q <= e_calc);

	// bin end, clipped at max_size
	logic [SIZE_BITS+1:0] end_full;
	logic [SIZE_BITS-1:0] end_clip;
	logic                 bin_hit;
	always_comb begin
		end_full = (SIZE_BITS+2)'(start_q) + (SIZE_BITS+2)'(w_q) - (SIZE_BITS+2)'(1);
		if (end_full > (SIZE_BITS+2)'(cfg.max_size))
			end_clip = cfg.max_size;
		else
			end_clip = end_full[SIZE_BITS-1:0];
		bin_hit = (n_q <= end_clip);
	end

	// next geometric width: max(w+1, ceil(w*ratio)), saturated
	logic [PROD_BITS:0]                  rounded;
	logic [PROD_BITS-RATIO_FRAC_BITS:0]  grown;
	logic [PROD_BITS-RATIO_FRAC_BITS:0]  inc;
	logic [PROD_BITS-RATIO_FRAC_BITS:0]  w_pick;
	logic [WID_BITS-1:0]                 w_next;
	always_comb begin
		rounded = (PROD_BITS+1)'(prod) + RATIO_ROUND;
		grown   = rounded[PROD_BITS:RATIO_FRAC_BITS];
		inc     = (PROD_BITS-RATIO_FRAC_BITS+1)'(w_q) + 1'b1;
		w_pick  = (grown > inc) ? grown : inc;
		if (w_pick > (PROD_BITS-RATIO_FRAC_BITS+1)'(WIDTH_CAP))
			w_next = WIDTH_CAP;
		else
			w_next = w_pick[WID_BITS-1:0];
	end

	logic [COMP_BITS:0] comp_base;
	assign comp_base = (COMP_BITS+1)'(e_q) + ((COMP_BITS+1)'(g_q) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_SETUP;
				ST_SETUP: begin
					if (out_of_range || expl_hit) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (bin_hit)
						state_q <= ST_SQR;
					else if (cfg.geometric_mode)
						state_q <= ST_GROW;
				end
				ST_GROW: state_q <= ST_WALK;
				ST_SQR:  state_q <= ST_OUT;
				ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) n_q <= size_query;
			ST_SETUP: begin
				e_q     <= e_calc;
				start_q <= e_calc + SIZE_BITS'(1);
				w_q     <= (cfg.first_bin_width == '0) ? WID_BITS'(1)
				                                      : WID_BITS'(cfg.first_bin_width);
				g_q     <= '0;
				in_range_q    <= !out_of_range;
				is_explicit_q <= !out_of_range;
				comp_q        <= out_of_range ? '0 : COMP_BITS'(n_q - SIZE_BITS'(1));
				second_q      <= '0;
				group_q       <= out_of_range ? '0 : '1;
				first_q       <= '0;
				last_q        <= '0;
				span_out_q    <= '0;
				mean_q        <= '0;
				var_q         <= '0;
			end
			ST_WALK: begin
				if (bin_hit) begin
					end_q  <= end_clip;
					span_q <= end_clip - start_q + SIZE_BITS'(1);
				end else begin
					start_q <= end_clip + SIZE_BITS'(1);
					g_q     <= g_q + SIZE_BITS'(1);
				end
			end
			ST_GROW: w_q <= w_next;
			ST_SQR: ;
			ST_OUT: begin
				in_range_q    <= 1'b1;
				is_explicit_q <= 1'b0;
				comp_q        <= comp_base[COMP_BITS-1:0];
				second_q      <= comp_base[COMP_BITS-1:0] + COMP_BITS'(1);
				group_q       <= COMP_BITS'(g_q);
				first_q       <= start_q;
				last_q        <= end_q;
				span_out_q    <= span_q;
				mean_q        <= COMP_BITS'(start_q) + COMP_BITS'(end_q);
				var_q         <= prod[VAR_BITS-1:0] - VAR_BITS'(1);
			end
			default: ;
		endcase
	end

	assign busy                  = (state_q != ST_IDLE);
	assign done                  = done_q;
	assign in_range              = in_range_q;
	assign is_explicit           = is_explicit_q;
	assign component_index       = comp_q;
	assign second_component      = second_q;
	assign group_number          = group_q;
	assign bin_first             = first_q;
	assign bin_last              = last_q;
	assign bin_span              = span_out_q;
	assign mean_doubled          = mean_q;
	assign variance_times_twelve = var_q;

endmodule

### rtl/cluster_size_bin_mapper_top.sv
// ---------------------------------------------------------------------------
// cluster_size_bin_mapper_top
// Maps a cluster size to its explicit component or to its grouped bin.
// ---------------------------------------------------------------------------
// A query is taken when start is high and busy is low; busy stays high until
// the result appears on the result ports for exactly one cycle with done
// high, and the receiver must take it then. Out-of-range and explicit sizes
// finish in the setup state. Grouped sizes walk the bins one at a time
// through a shared adder/compare: one walk step per bin in linear mode, a
// walk and a grow step per bin in geometric mode (the shared multiplier
// computes the next width); after the hit bin a square step uses the
// multiplier for the variance, then an output step. With small linear
// widths the bin number can reach tens of thousands. Configuration writes
// are accepted every cycle and must only be issued while the block is idle.
// ---------------------------------------------------------------------------
module cluster_size_bin_mapper_top import cbm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SIZE_BITS-1:0]    cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic [SIZE_BITS-1:0]    size_query,
	output logic                    done,
	output logic                    in_range,
	output logic                    is_explicit,
	output logic [COMP_BITS-1:0]    component_index,
	output logic [COMP_BITS-1:0]    second_component,
	output logic signed [COMP_BITS-1:0] group_number,
	output logic [SIZE_BITS-1:0]    bin_first,
	output logic [SIZE_BITS-1:0]    bin_last,
	output logic [SIZE_BITS-1:0]    bin_span,
	output logic [COMP_BITS-1:0]    mean_doubled,
	output logic [VAR_BITS-1:0]     variance_times_twelve
);

	cfg_t cfg;

	cbm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cbm_walker u_walker (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg                   (cfg),
		.start                 (start),
		.busy                  (busy),
		.size_query            (size_query),
		.done                  (done),
		.in_range              (in_range),
		.is_explicit           (is_explicit),
		.component_index       (component_index),
		.second_component      (second_component),
		.group_number          (group_number),
		.bin_first             (bin_first),
		.bin_last              (bin_last),
		.bin_span              (bin_span),
		.mean_doubled          (mean_doubled),
		.variance_times_twelve (variance_times_twelve)
	);

endmodule

### rtl/cbm_checker.sv
// ---------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the bin mapper, bound to the top level.
// ---------------------------------------------------------------------------
module cbm_checker import cbm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic                    in_range,
	input logic                    is_explicit,
	input logic [COMP_BITS-1:0]    component_index,
	input logic [COMP_BITS-1:0]    second_component,
	input logic [COMP_BITS-1:0]    group_number,
	input logic [SIZE_BITS-1:0]    bin_first,
	input logic [SIZE_BITS-1:0]    bin_last,
	input logic [SIZE_BITS-1:0]    bin_span,
	input logic [COMP_BITS-1:0]    mean_doubled,
	input logic [VAR_BITS-1:0]     variance_times_twelve
);

	// a result only shows up as the query finishes
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a query in flight");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("query transfer did not start work");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> !is_explicit && component_index == '0 &&
			group_number == '0 && bin_span == '0 && variance_times_twelve == '0)
		else $error("out-of-range result not cleared");

	a_explicit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_explicit |-> in_range && group_number == '1 &&
			second_component == '0 && bin_span == '0)
		else $error("explicit result fields wrong");

	a_bin_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_range && !is_explicit |->
			mean_doubled == COMP_BITS'(bin_first) + COMP_BITS'(bin_last) &&
			second_component == component_index + COMP_BITS'(1) &&
			bin_span == bin_last - bin_first + SIZE_BITS'(1))
		else $error("bin result fields inconsistent");

endmodule

bind cluster_size_bin_mapper_top cbm_checker u_cbm_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.start                 (start),
	.busy                  (busy),
	.done                  (done),
	.in_range              (in_range),
	.is_explicit           (is_explicit),
	.component_index       (component_index),
	.second_component      (second_component),
	.group_number          (group_number),
	.bin_first             (bin_first),
	.bin_last              (bin_last),
	.bin_span              (bin_span),
	.mean_doubled          (mean_doubled),
	.variance_times_twelve (variance_times_twelve)
);
